/* design/sta_pkg.sv */
`timescale 1ns / 1ps

package sta_pkg;

    // command codes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SUB   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_DUMP  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_MERGED   = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;
    localparam logic [2:0] ST_DUMP     = 3'd6;

    localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] coefficient;
        logic signed [15:0] exponent;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] term_coefficient;
        logic signed [15:0] term_exponent;
        logic [4:0]         term_total;
        logic               term_valid;
        logic               last;
    } t_result;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic signed [15:0] exponent;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MERGE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

endpackage

/* design/sparse_term_accumulator_top.sv */
`timescale 1ns / 1ps

// Sparse polynomial term table. Holds up to CAPACITY terms (signed Q16.16
// coefficient, signed 16-bit exponent) in insertion order, in a table
// memory with one write port and one registered read port. A command is
// taken when start is high and busy is low; busy then stays high until the
// command's last result has been issued. Results come out as one-cycle pulses
// of o_result_valid and must be captured on that cycle: there is no way to
// hold them off. A clear, a zero term and a dump of an empty table finish in
// the dispatch state; an add or subtract scans the stored entries in order,
// then merges or appends; a merge that cancels to zero then compacts the
// table, moving each later entry down by one; a dump gives one result per
// stored term. Every scan, shift and dump step goes through the registered
// read of the table memory: a read state, then a compare, write or output
// state. The longest commands are an append or drop after a full scan, or a
// cancel whose scan and compaction together cover the whole table.
module sparse_term_accumulator_top #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sta_pkg::t_cmd    i_cmd,
    output logic             o_result_valid,
    output sta_pkg::t_result o_result
);
    import sta_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // table index
    localparam int CW = $clog2(CAPACITY + 1);                   // entry count

    // control
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_hit, n_hit;
    logic            r_out_valid, n_out_valid;

    // latched command, coefficient already negated for subtract
    logic [1:0]         r_mode;
    logic signed [31:0] r_coef;
    logic signed [15:0] r_exp;
    logic signed [31:0] r_sum, n_sum;
    t_result            r_out, n_out;

    // table memory
    t_entry          r_mem [CAPACITY];
    t_entry          r_rdata;
    logic            mem_re, mem_we;
    logic [IW-1:0]   mem_raddr, mem_waddr;
    t_entry          mem_wdata;

    logic            accept;
    logic signed [31:0] in_coef;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic            exp_match;
    logic            idx_is_last;
    logic            hit_has_tail;
    logic            room;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // subtract negates with saturation: -(-2^31) becomes 2^31-1
    always_comb begin
        if (i_cmd.mode == MODE_SUB) begin
            in_coef = (i_cmd.coefficient == COEF_MIN) ? COEF_MAX : -i_cmd.coefficient;
        end else begin
            in_coef = i_cmd.coefficient;
        end
    end

    // saturating adder, used on the matched entry
    assign sum_wide = {r_rdata.coefficient[31], r_rdata.coefficient}
                    + {r_coef[31], r_coef};
    always_comb begin
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? COEF_MIN : COEF_MAX;
        end else begin
            sum_sat = sum_wide[31:0];
        end
    end

    assign exp_match    = (r_rdata.exponent == r_exp);
    assign idx_is_last  = (CW'(r_idx + CW'(1)) == r_count);
    assign hit_has_tail = ((CW'(r_hit) + CW'(1)) < r_count);
    assign room         = (r_count < CW'(CAPACITY));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (r_mode)
                    MODE_CLEAR: n_state = S_IDLE;
                    MODE_DUMP:  n_state = (r_count == '0) ? S_IDLE : S_DUMP_RD;
                    default: begin
                        if (r_coef == '0)        n_state = S_IDLE;
                        else if (r_count == '0)  n_state = S_APPEND;
                        else                     n_state = S_SCAN_RD;
                    end
                endcase
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (exp_match)        n_state = S_MERGE;
                else if (idx_is_last) n_state = S_APPEND;
                else                  n_state = S_SCAN_RD;
            end
            S_MERGE: begin
                if (r_sum == '0 && hit_has_tail) n_state = S_SHIFT_RD;
                else                             n_state = S_IDLE;
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = idx_is_last ? S_IDLE : S_SHIFT_RD;
            S_APPEND:   n_state = S_IDLE;
            S_DUMP_RD:  n_state = S_DUMP_OUT;
            S_DUMP_OUT: n_state = idx_is_last ? S_IDLE : S_DUMP_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath, memory strobes and results
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_sum       = r_sum;
        n_out_valid = 1'b0;
        n_out       = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_idx[IW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_idx[IW-1:0];
        mem_wdata   = r_rdata;

        unique case (r_state)
            S_IDLE: ;
            S_DISPATCH: begin
                n_idx = '0;
                unique case (r_mode)
                    MODE_CLEAR: begin
                        n_count      = '0;
                        n_out_valid  = 1'b1;
                        n_out.status = ST_CLEARED;
                        n_out.last   = 1'b1;
                    end
                    MODE_DUMP: begin
                        if (r_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out.status = ST_DUMP;
                            n_out.last   = 1'b1;
                        end
                    end
                    default: begin
                        if (r_coef == '0) begin
                            n_out_valid  = 1'b1;
                            n_out.status = ST_IGNORED;
                            n_out.last   = 1'b1;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                mem_re = 1'b1;
            end
            S_SCAN_CMP: begin
                if (exp_match) begin
                    n_hit = r_idx[IW-1:0];
                    n_sum = sum_sat;
                end else begin
                    n_idx = CW'(r_idx + CW'(1));
                end
            end
            S_MERGE: begin
                if (r_sum == '0) begin
                    if (hit_has_tail) begin
                        n_idx = CW'(CW'(r_hit) + CW'(1));
                    end else begin
                        n_count                = CW'(r_count - CW'(1));
                        n_out_valid            = 1'b1;
                        n_out.status           = ST_REMOVED;
                        n_out.term_exponent    = r_exp;
                        n_out.term_valid       = 1'b1;
                        n_out.last             = 1'b1;
                    end
                end else begin
                    mem_we                 = 1'b1;
                    mem_waddr              = r_hit;
                    mem_wdata.coefficient  = r_sum;
                    mem_wdata.exponent     = r_exp;
                    n_out_valid            = 1'b1;
                    n_out.status           = ST_MERGED;
                    n_out.term_coefficient = r_sum;
                    n_out.term_exponent    = r_exp;
                    n_out.term_valid       = 1'b1;
                    n_out.last             = 1'b1;
                end
            end
            S_SHIFT_RD: begin
                mem_re = 1'b1;
            end
            S_SHIFT_WR: begin
                // move entry idx down into idx-1
                mem_we    = 1'b1;
                mem_waddr = IW'(r_idx - CW'(1));
                mem_wdata = r_rdata;
                if (idx_is_last) begin
                    n_count             = CW'(r_count - CW'(1));
                    n_out_valid         = 1'b1;
                    n_out.status        = ST_REMOVED;
                    n_out.term_exponent = r_exp;
                    n_out.term_valid    = 1'b1;
                    n_out.last          = 1'b1;
                end else begin
                    n_idx = CW'(r_idx + CW'(1));
                end
            end
            S_APPEND: begin
                n_out_valid = 1'b1;
                n_out.last  = 1'b1;
                if (room) begin
                    mem_we                 = 1'b1;
                    mem_waddr              = r_count[IW-1:0];
                    mem_wdata.coefficient  = r_coef;
                    mem_wdata.exponent     = r_exp;
                    n_count                = CW'(r_count + CW'(1));
                    n_out.status           = ST_INSERTED;
                    n_out.term_coefficient = r_coef;
                    n_out.term_exponent    = r_exp;
                    n_out.term_valid       = 1'b1;
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            S_DUMP_RD: begin
                mem_re = 1'b1;
            end
            S_DUMP_OUT: begin
                n_out_valid            = 1'b1;
                n_out.status           = ST_DUMP;
                n_out.term_coefficient = r_rdata.coefficient;
                n_out.term_exponent    = r_rdata.exponent;
                n_out.term_valid       = 1'b1;
                n_out.last             = idx_is_last;
                n_idx                  = CW'(r_idx + CW'(1));
            end
            default: ;
        endcase

        // total reflects the table after this step
        n_out.term_total = 5'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_cmd.mode;
            r_coef <= in_coef;
            r_exp  <= i_cmd.exponent;
        end
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_sum <= n_sum;
        r_out <= n_out;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // the last result of a command is issued as busy drops
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_result_valid && o_result.last))
        else $error("busy dropped without a final result");

    a_last_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> !busy)
        else $error("final result issued while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last) |-> busy)
        else $error("intermediate dump result without busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command transfer did not raise busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sta_pkg::*;

    localparam int TERM_SLOTS     = 16;   // table capacity of the instance
    localparam int POOL_SIZE      = 20;   // a few more exponents than slots, so the table fills
    localparam int RANDOM_ITEMS   = 405;
    localparam int WATCHDOG_LIMIT = 4000; // quiet cycles; well above the worst item plus the longest gap
    localparam int TAIL_CYCLES    = 80;   // drain time past the last result, above the worst latency

    // Predicts the term table and holds the results still owed by the block.
    class term_table_tracker;
        localparam int DEPTH = 16;

        logic signed [31:0] coef_tbl[DEPTH];
        logic signed [15:0] exp_tbl[DEPTH];
        int unsigned        n_terms;
        t_result            pending_results[$];
        int unsigned        mismatch_count;

        function new();
            n_terms        = 0;
            mismatch_count = 0;
        endfunction

        function logic signed [31:0] saturate(logic signed [32:0] v);
            if (v > 33'sh0_7FFF_FFFF) begin
                return COEF_MAX;
            end
            if (v < -33'sh0_8000_0000) begin
                return COEF_MIN;
            end
            return v[31:0];
        endfunction

        // term_total always reflects the table after the step
        function void owe(logic [2:0] status, logic signed [31:0] coef, logic signed [15:0] expo,
                          logic valid, logic last);
            t_result r;
            r.status           = status;
            r.term_coefficient = coef;
            r.term_exponent    = expo;
            r.term_total       = n_terms[4:0];
            r.term_valid       = valid;
            r.last             = last;
            pending_results.push_back(r);
        endfunction

        // Called once per accepted command transfer.
        function void note_command(t_cmd cmd);
            logic signed [32:0] term;
            logic signed [31:0] sum;
            int                 hit;
            hit = -1;
            case (cmd.mode)
                MODE_CLEAR: begin
                    n_terms = 0;
                    owe(ST_CLEARED, '0, '0, 1'b0, 1'b1);
                end
                MODE_DUMP: begin
                    if (n_terms == 0) begin
                        owe(ST_DUMP, '0, '0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < n_terms; i++) begin
                            owe(ST_DUMP, coef_tbl[i], exp_tbl[i], 1'b1, i == n_terms - 1);
                        end
                    end
                end
                default: begin
                    term = 33'(cmd.coefficient);
                    // negating the most negative value saturates to the most positive
                    if (cmd.mode == MODE_SUB) begin
                        term = 33'(saturate(-term));
                    end
                    if (term == 0) begin
                        owe(ST_IGNORED, '0, '0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < n_terms; i++) begin
                            if (hit < 0 && exp_tbl[i] == cmd.exponent) begin
                                hit = i;
                            end
                        end
                        if (hit >= 0) begin
                            sum = saturate(33'(coef_tbl[hit]) + term);
                            if (sum == 0) begin
                                // cancelled: later terms move down, order kept
                                for (int i = hit; i + 1 < n_terms; i++) begin
                                    coef_tbl[i] = coef_tbl[i + 1];
                                    exp_tbl[i]  = exp_tbl[i + 1];
                                end
                                n_terms--;
                                owe(ST_REMOVED, '0, cmd.exponent, 1'b1, 1'b1);
                            end else begin
                                coef_tbl[hit] = sum;
                                owe(ST_MERGED, sum, cmd.exponent, 1'b1, 1'b1);
                            end
                        end else if (n_terms < DEPTH) begin
                            coef_tbl[n_terms] = term[31:0];
                            exp_tbl[n_terms]  = cmd.exponent;
                            n_terms++;
                            owe(ST_INSERTED, term[31:0], cmd.exponent, 1'b1, 1'b1);
                        end else begin
                            owe(ST_FULL, '0, '0, 1'b0, 1'b1);
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("term_coefficient", want.term_coefficient, got.term_coefficient);
            compare_field("term_exponent", want.term_exponent, got.term_exponent);
            compare_field("term_total", want.term_total, got.term_total);
            compare_field("term_valid", want.term_valid, got.term_valid);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    term_table_tracker tracker = new();

    // exponents that random commands draw from; refreshed on every random clear
    logic signed [15:0] exp_pool[POOL_SIZE];
    int unsigned        quiet_cycles = 0;

    sparse_term_accumulator_top #(
        .CAPACITY(TERM_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Results are one-cycle strobes that cannot be held off; sample them
    // mid-cycle, well away from the edge that updates them.
    always @(negedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            tracker.check_result(o_result);
        end
    end

    // Watchdog: any transfer in either direction resets the quiet count.
    always @(negedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_cmd make_cmd(logic [1:0] mode, logic signed [31:0] coef,
                                      logic signed [15:0] expo);
        t_cmd cmd;
        cmd.mode        = mode;
        cmd.coefficient = coef;
        cmd.exponent    = expo;
        return cmd;
    endfunction

    function automatic void refresh_pool();
        foreach (exp_pool[i]) begin
            exp_pool[i] = 16'($urandom);
        end
    endfunction

    // Mostly back-to-back or short gaps, a few long ones; one stretch of
    // the random run goes fully back-to-back.
    function automatic int unsigned pick_gap(int unsigned item);
        int unsigned roll;
        if (item >= 150 && item < 230) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random command shaped to exercise the table: exponents come from a
    // small pool so terms collide and the table fills, and a good share of
    // commands aim at a stored term to cancel it exactly.
    function automatic t_cmd random_command();
        t_cmd        cmd;
        int unsigned roll;
        int unsigned pick;
        roll            = $urandom_range(0, 99);
        cmd.mode        = $urandom_range(0, 1) ? MODE_SUB : MODE_ADD;
        cmd.coefficient = $urandom;
        cmd.exponent    = exp_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 2) begin
            cmd.mode = MODE_CLEAR;
            refresh_pool();
        end else if (roll < 10) begin
            cmd.mode = MODE_DUMP;
        end else if (roll < 14) begin
            cmd.coefficient = '0;
        end else if (roll < 30 && tracker.n_terms != 0) begin
            pick         = $urandom_range(0, tracker.n_terms - 1);
            cmd.exponent = tracker.exp_tbl[pick];
            if (tracker.coef_tbl[pick] == COEF_MIN || $urandom_range(0, 1)) begin
                // subtracting the minimum saturates, so that one only merges
                cmd.mode        = MODE_SUB;
                cmd.coefficient = tracker.coef_tbl[pick];
            end else begin
                cmd.mode        = MODE_ADD;
                cmd.coefficient = -tracker.coef_tbl[pick];
            end
        end else begin
            case ($urandom_range(0, 5))
                0:       cmd.coefficient = COEF_MAX;
                1:       cmd.coefficient = COEF_MIN;
                2, 3:    cmd.coefficient = $signed($urandom_range(0, 131072)) - 65536;
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                cmd.exponent = 16'($urandom);
            end
        end
        return cmd;
    endfunction

    // Present one command and hold it until the block takes it. Returns at
    // the accepting edge; start is only ever written once per time step.
    task automatic issue(input t_cmd cmd, input int unsigned gap);
        logic ready;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do begin
            @(negedge i_clk);
            ready = !busy;
            @(posedge i_clk);
        end while (!ready);
        tracker.note_command(cmd);
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (tracker.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table cases, zero terms, extreme coefficients and
        // exponents, saturation both ways, removal from the middle.
        issue(make_cmd(MODE_DUMP, '0, '0), pick_gap(0));
        issue(make_cmd(MODE_CLEAR, '0, '0), pick_gap(0));
        issue(make_cmd(MODE_ADD, '0, 16'sh1234), pick_gap(0));
        issue(make_cmd(MODE_SUB, '0, 16'sh7FFF), pick_gap(0));
        issue(make_cmd(MODE_ADD, COEF_MIN, 16'sh8000), pick_gap(0));
        // minus the minimum saturates to the maximum
        issue(make_cmd(MODE_SUB, COEF_MIN, 16'sh7FFF), pick_gap(0));
        // positive overflow on merge
        issue(make_cmd(MODE_ADD, COEF_MAX, 16'sh7FFF), pick_gap(0));
        // negative overflow on merge
        issue(make_cmd(MODE_ADD, COEF_MIN, 16'sh8000), pick_gap(0));
        issue(make_cmd(MODE_ADD, 32'sh0005_0000, 16'sh0000), pick_gap(0));
        issue(make_cmd(MODE_ADD, 32'sh0007_8000, -16'sh0001), pick_gap(0));
        issue(make_cmd(MODE_DUMP, '0, '0), pick_gap(0));
        // cancel a middle entry; the one after it shifts down
        issue(make_cmd(MODE_SUB, 32'sh0005_0000, 16'sh0000), pick_gap(0));
        issue(make_cmd(MODE_ADD, COEF_MAX, 16'sh8000), pick_gap(0));
        issue(make_cmd(MODE_ADD, 32'sh0007_8000, -16'sh0001), pick_gap(0));
        issue(make_cmd(MODE_DUMP, '0, '0), pick_gap(0));
        issue(make_cmd(MODE_CLEAR, 32'shFFFF_FFFF, 16'shFFFF), pick_gap(0));
        issue(make_cmd(MODE_DUMP, '0, '0), pick_gap(0));
        wait_for_results();

        refresh_pool();
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100 || n == 300) begin
                wait_for_results();
                issue(random_command(), 1 + pick_gap(n));
            end else begin
                issue(random_command(), pick_gap(n));
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sparse_term_accumulator_top.f */
design/sta_pkg.sv
design/sparse_term_accumulator_top.sv
dv/testbench.sv
